// ----- rtl/pfe_pkg.sv -----
// Package for the palette fade engine: sizes, codes and shared types.
// Used by pfe_step_unit, pfe_palette_store and palette_fade_engine.
package pfe_pkg;

  localparam int BANK_ENTRIES  = 64;
  localparam int FADE_STEPS    = 22;

  localparam int ENTRY_AW      = $clog2(BANK_ENTRIES);
  localparam int ADDR_W        = ENTRY_AW + 1;
  localparam int MEM_DEPTH     = 2 ** ADDR_W;
  localparam int ENTRY_FIELD_W = 6;
  localparam int RANGE_W       = ((ENTRY_AW > ENTRY_FIELD_W) ? ENTRY_AW : ENTRY_FIELD_W) + 1;
  localparam int STEP_W        = $clog2(FADE_STEPS + 1);
  localparam int KIND_W        = 3;
  localparam int MODE_W        = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 6;

  localparam logic [7:0] STEP_DELTA  = 8'd32;
  localparam logic [7:0] WHITE_LEVEL = 8'd224;

  localparam logic [RANGE_W-1:0]  BANK_LAST_W = RANGE_W'(BANK_ENTRIES - 1);
  localparam logic [RANGE_W-1:0]  BANK_SIZE_W = RANGE_W'(BANK_ENTRIES);
  localparam logic [ENTRY_AW-1:0] ENTRY_LAST  = ENTRY_AW'(BANK_ENTRIES - 1);
  localparam logic [STEP_W-1:0]   STEPS_LAST  = STEP_W'(FADE_STEPS);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WR_TARGET  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_CURRENT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RD_CURRENT = 3'd4;

  // Fade modes
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_IN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLASH_IN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH_OUT = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENTRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BANK   = 2'd2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic              cur_we;
    logic              tgt_we;
    logic [ADDR_W-1:0] wr_addr;
    rgb_t              wr_rgb;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

// ----- rtl/palette_fade_engine.sv -----
// Top level of the palette fade engine: item sequencer, config registers.
// Depends on pfe_pkg, pfe_palette_store and pfe_step_unit.
//
// Channel   Direction  Signals                                   Handshake
// item      in         kind_i bank_i entry_i red_in_i green_in_i  start & !busy
//                      blue_in_i fade_mode_i
// result    out        red_out_o green_out_o blue_out_o          result_valid_o, one cycle
//                      done_res_o
// config    in         cfg_idx_i cfg_data_i                      cfg_we_i
//
// A start paints a range of bank 0 for fade-in with a non-empty range and for
// flash-in. A tick steps its entries: the sweep reads and writes back one entry
// per cycle through the single read and write port of the current palette
// memory.
// Reset clears the state, fade mode, step and current palette valid bits, so the
// palette reads as black at once; no clearing pass is needed. Busy stays high
// until the result strobe; the receiver cannot stall, so results are never held back.
module palette_fade_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pfe_pkg::KIND_W-1:0]        kind_i,
  input  logic                              bank_i,
  input  logic [pfe_pkg::ENTRY_FIELD_W-1:0] entry_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  input  logic [pfe_pkg::MODE_W-1:0]        fade_mode_i,
  output logic                              result_valid_o,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              done_res_o,
  input  logic                              cfg_we_i,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] S_EXEC = 3'd1;
  localparam logic [STATE_W-1:0] S_READ = 3'd2;
  localparam logic [STATE_W-1:0] S_FILL = 3'd3;
  localparam logic [STATE_W-1:0] S_TICK = 3'd4;

  localparam int EAW = pfe_pkg::ENTRY_AW;
  localparam int AW  = pfe_pkg::ADDR_W;

  logic [STATE_W-1:0] state_q, state_d;

  // Config registers
  logic [pfe_pkg::CFG_DATA_W-1:0] first_q, off_q;
  logic                           skip_q;

  // Latched item
  logic [pfe_pkg::KIND_W-1:0] kind_q;
  logic                       bank_q;
  logic [EAW-1:0]             entry_q;
  logic                       in_range_q;
  pfe_pkg::rgb_t              rgb_q;
  logic [pfe_pkg::MODE_W-1:0] fmode_q;

  // Fade state
  logic [pfe_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [pfe_pkg::STEP_W-1:0] step_q, step_d;

  // Sweep pointer and write-back stage
  logic [EAW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_entry_q, ptr_entry_d;
  logic           last_bank_q, last_bank_d, ptr_bank_q, ptr_bank_d;
  logic           issue_done_q, issue_done_d, wb_valid_q, wb_valid_d;
  logic [AW-1:0]  wb_addr_q, wb_addr_d;

  // Result registers
  logic          res_valid_q, res_valid_d, res_done_q, res_done_d;
  pfe_pkg::rgb_t res_rgb_q, res_rgb_d;

  pfe_pkg::store_req_t req;
  pfe_pkg::rgb_t       cur_rd, tgt_rd, step_rgb;

  logic [pfe_pkg::RANGE_W-1:0] lo_w, top_w, hi_w;
  logic                        range_empty, ptr_last, fmode_ok, fade_end;
  logic [pfe_pkg::STEP_W-1:0]  step_inc;
  logic [AW-1:0]               ptr_addr, item_addr;
  logic                        accept;

  pfe_palette_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .cur_rd_o(cur_rd),
    .tgt_rd_o(tgt_rd)
  );

  pfe_step_unit u_step (
    .mode_i(mode_q),
    .cur_i (cur_rd),
    .tgt_i (tgt_rd),
    .next_o(step_rgb)
  );

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Fade-in range, clipped to the bank
  assign lo_w        = pfe_pkg::RANGE_W'(first_q);
  assign top_w       = lo_w + pfe_pkg::RANGE_W'(off_q);
  assign range_empty = (lo_w > pfe_pkg::BANK_LAST_W);
  assign hi_w        = (top_w > pfe_pkg::BANK_LAST_W) ? pfe_pkg::BANK_LAST_W : top_w;

  assign ptr_addr  = {ptr_bank_q, ptr_entry_q};
  assign item_addr = {bank_q, entry_q};
  assign ptr_last  = (ptr_entry_q == hi_q) && (ptr_bank_q == last_bank_q);

  assign fmode_ok = (fmode_q == pfe_pkg::MODE_FADE_IN) || (fmode_q == pfe_pkg::MODE_FADE_OUT) ||
                    (fmode_q == pfe_pkg::MODE_FLASH_IN) || (fmode_q == pfe_pkg::MODE_FLASH_OUT);

  assign step_inc = step_q + 1'b1;
  assign fade_end = (step_inc >= pfe_pkg::STEPS_LAST);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    step_d       = step_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    last_bank_d  = last_bank_q;
    ptr_bank_d   = ptr_bank_q;
    ptr_entry_d  = ptr_entry_q;
    issue_done_d = issue_done_q;
    wb_valid_d   = 1'b0;
    wb_addr_d    = wb_addr_q;
    res_valid_d  = 1'b0;
    res_done_d   = 1'b0;
    res_rgb_d    = '0;
    req          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end

      S_EXEC: begin
        unique case (kind_q)
          pfe_pkg::KIND_WR_TARGET, pfe_pkg::KIND_WR_CURRENT: begin
            req.tgt_we  = in_range_q && (kind_q == pfe_pkg::KIND_WR_TARGET);
            req.cur_we  = in_range_q && (kind_q == pfe_pkg::KIND_WR_CURRENT);
            req.wr_addr = item_addr;
            req.wr_rgb  = rgb_q;
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
          pfe_pkg::KIND_RD_CURRENT: begin
            req.rd_en   = 1'b1;
            req.rd_addr = item_addr;
            state_d     = S_READ;
          end
          pfe_pkg::KIND_START: begin
            // Restart from step zero; bad modes drop to idle
            step_d      = '0;
            mode_d      = fmode_ok ? fmode_q : pfe_pkg::MODE_IDLE;
            ptr_bank_d  = 1'b0;
            last_bank_d = 1'b0;
            if (fmode_q == pfe_pkg::MODE_FADE_IN && !range_empty) begin
              lo_d        = EAW'(lo_w);
              hi_d        = EAW'(hi_w);
              ptr_entry_d = EAW'(lo_w);
              state_d     = S_FILL;
            end else if (fmode_q == pfe_pkg::MODE_FLASH_IN) begin
              lo_d        = '0;
              hi_d        = pfe_pkg::ENTRY_LAST;
              ptr_entry_d = '0;
              state_d     = S_FILL;
            end else begin
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          pfe_pkg::KIND_TICK: begin
            if (mode_q == pfe_pkg::MODE_IDLE) begin
              res_valid_d = 1'b1;
              res_done_d  = 1'b1;
              state_d     = S_IDLE;
            end else if (mode_q == pfe_pkg::MODE_FADE_IN && range_empty) begin
              // Nothing to step, but the frame still counts
              res_valid_d = 1'b1;
              res_done_d  = fade_end;
              step_d      = fade_end ? '0 : step_inc;
              if (fade_end) mode_d = pfe_pkg::MODE_IDLE;
              state_d     = S_IDLE;
            end else begin
              if (mode_q == pfe_pkg::MODE_FADE_IN) begin
                lo_d = EAW'(lo_w);
                hi_d = EAW'(hi_w);
              end else begin
                lo_d = '0;
                hi_d = pfe_pkg::ENTRY_LAST;
              end
              if (mode_q == pfe_pkg::MODE_FADE_IN || mode_q == pfe_pkg::MODE_FLASH_IN) begin
                last_bank_d = !skip_q;
              end else begin
                last_bank_d = 1'b1;
              end
              ptr_bank_d   = 1'b0;
              ptr_entry_d  = (mode_q == pfe_pkg::MODE_FADE_IN) ? EAW'(lo_w) : '0;
              issue_done_d = 1'b0;
              state_d      = S_TICK;
            end
          end
          default: begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        res_valid_d = 1'b1;
        res_rgb_d   = in_range_q ? cur_rd : '0;
        state_d     = S_IDLE;
      end

      S_FILL: begin
        // Paint bank 0 black for fade-in, white for flash-in
        req.cur_we  = 1'b1;
        req.wr_addr = ptr_addr;
        req.wr_rgb  = (mode_q == pfe_pkg::MODE_FADE_IN) ? '0 :
                      {pfe_pkg::WHITE_LEVEL, pfe_pkg::WHITE_LEVEL, pfe_pkg::WHITE_LEVEL};
        if (ptr_entry_q == hi_q) begin
          ptr_entry_d = lo_q;
        end else begin
          ptr_entry_d = ptr_entry_q + 1'b1;
        end
        if (ptr_last) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_TICK: begin
        // Read one entry per cycle, write back the one read in the cycle before
        if (!issue_done_q) begin
          req.rd_en   = 1'b1;
          req.rd_addr = ptr_addr;
          wb_valid_d  = 1'b1;
          wb_addr_d   = ptr_addr;
          if (ptr_entry_q == hi_q) begin
            ptr_bank_d  = 1'b1;
            ptr_entry_d = lo_q;
          end else begin
            ptr_entry_d = ptr_entry_q + 1'b1;
          end
          if (ptr_last) issue_done_d = 1'b1;
        end
        if (wb_valid_q) begin
          req.cur_we  = 1'b1;
          req.wr_addr = wb_addr_q;
          req.wr_rgb  = step_rgb;
        end
        if (issue_done_q && !wb_valid_q) begin
          res_valid_d = 1'b1;
          res_done_d  = fade_end;
          step_d      = fade_end ? '0 : step_inc;
          if (fade_end) mode_d = pfe_pkg::MODE_IDLE;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= pfe_pkg::MODE_IDLE;
      step_q       <= '0;
      issue_done_q <= 1'b0;
      wb_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      res_done_q   <= 1'b0;
      res_rgb_q    <= '0;
      first_q      <= '0;
      off_q        <= pfe_pkg::CFG_DATA_W'(63);
      skip_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      step_q       <= step_d;
      issue_done_q <= issue_done_d;
      wb_valid_q   <= wb_valid_d;
      res_valid_q  <= res_valid_d;
      res_done_q   <= res_done_d;
      res_rgb_q    <= res_rgb_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pfe_pkg::CFG_FIRST_ENTRY: first_q <= cfg_data_i;
          pfe_pkg::CFG_LAST_OFFSET: off_q   <= cfg_data_i;
          pfe_pkg::CFG_SKIP_BANK:   skip_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_i;
      bank_q     <= bank_i;
      entry_q    <= EAW'(entry_i);
      in_range_q <= (pfe_pkg::RANGE_W'(entry_i) < pfe_pkg::BANK_SIZE_W);
      rgb_q      <= {red_in_i, green_in_i, blue_in_i};
      fmode_q    <= fade_mode_i;
    end
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    last_bank_q <= last_bank_d;
    ptr_bank_q  <= ptr_bank_d;
    ptr_entry_q <= ptr_entry_d;
    wb_addr_q   <= wb_addr_d;
  end

  assign result_valid_o = res_valid_q;
  assign red_out_o      = res_rgb_q.r;
  assign green_out_o    = res_rgb_q.g;
  assign blue_out_o     = res_rgb_q.b;
  assign done_res_o     = res_done_q;

endmodule

// ----- rtl/pfe_step_unit.sv -----
// Shared per-entry step unit: moves at most one channel of one entry by 32.
// Depends on pfe_pkg.
module pfe_step_unit (
  input  logic [pfe_pkg::MODE_W-1:0] mode_i,
  input  pfe_pkg::rgb_t              cur_i,
  input  pfe_pkg::rgb_t              tgt_i,
  output pfe_pkg::rgb_t              next_o
);

  always_comb begin
    next_o = cur_i;
    unique case (mode_i)
      pfe_pkg::MODE_FADE_IN: begin
        if (tgt_i.b > cur_i.b) next_o.b = cur_i.b + pfe_pkg::STEP_DELTA;
        else if (tgt_i.g > cur_i.g) next_o.g = cur_i.g + pfe_pkg::STEP_DELTA;
        else if (tgt_i.r > cur_i.r) next_o.r = cur_i.r + pfe_pkg::STEP_DELTA;
      end
      pfe_pkg::MODE_FLASH_IN: begin
        if (tgt_i.b < cur_i.b) next_o.b = cur_i.b - pfe_pkg::STEP_DELTA;
        else if (tgt_i.g < cur_i.g) next_o.g = cur_i.g - pfe_pkg::STEP_DELTA;
        else if (tgt_i.r < cur_i.r) next_o.r = cur_i.r - pfe_pkg::STEP_DELTA;
      end
      pfe_pkg::MODE_FADE_OUT: begin
        if (cur_i.r != 8'd0) next_o.r = cur_i.r - pfe_pkg::STEP_DELTA;
        else if (cur_i.g != 8'd0) next_o.g = cur_i.g - pfe_pkg::STEP_DELTA;
        else if (cur_i.b != 8'd0) next_o.b = cur_i.b - pfe_pkg::STEP_DELTA;
      end
      pfe_pkg::MODE_FLASH_OUT: begin
        if (cur_i.r != pfe_pkg::WHITE_LEVEL) next_o.r = cur_i.r + pfe_pkg::STEP_DELTA;
        else if (cur_i.g != pfe_pkg::WHITE_LEVEL) next_o.g = cur_i.g + pfe_pkg::STEP_DELTA;
        else if (cur_i.b != pfe_pkg::WHITE_LEVEL) next_o.b = cur_i.b + pfe_pkg::STEP_DELTA;
      end
      default: next_o = cur_i;
    endcase
  end

endmodule

// ----- rtl/pfe_palette_store.sv -----
// Current and target palette memories, one write and one read port each.
// Current entries carry valid bits so they read as black after reset.
// Depends on pfe_pkg.
module pfe_palette_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfe_pkg::store_req_t req_i,
  output pfe_pkg::rgb_t       cur_rd_o,
  output pfe_pkg::rgb_t       tgt_rd_o
);

  pfe_pkg::rgb_t                     cur_mem [pfe_pkg::MEM_DEPTH];
  pfe_pkg::rgb_t                     tgt_mem [pfe_pkg::MEM_DEPTH];
  logic [pfe_pkg::MEM_DEPTH-1:0]     cur_vld_q;
  logic                              rd_vld_q;
  pfe_pkg::rgb_t                     cur_rd_q;
  pfe_pkg::rgb_t                     tgt_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.cur_we) begin
      cur_mem[req_i.wr_addr] <= req_i.wr_rgb;
    end
    if (req_i.tgt_we) begin
      tgt_mem[req_i.wr_addr] <= req_i.wr_rgb;
    end
    if (req_i.rd_en) begin
      cur_rd_q <= cur_mem[req_i.rd_addr];
      tgt_rd_q <= tgt_mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.cur_we) begin
        cur_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= cur_vld_q[req_i.rd_addr];
      end
    end
  end

  assign cur_rd_o = rd_vld_q ? cur_rd_q : '0;
  assign tgt_rd_o = tgt_rd_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for palette_fade_engine: queued items, a clocked driver and
// monitor, and a cycle-free palette predictor. Depends on pfe_pkg and the RTL.
module testbench;

  localparam int TOTAL_ENTRIES = 2 * pfe_pkg::BANK_ENTRIES;
  localparam int ITEM_BUDGET   = 750;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 200;
  localparam int RUN_LIMIT_NS  = 6_000_000;

  // One item as the block sees it, and the reply it causes.
  typedef struct packed {
    logic [pfe_pkg::KIND_W-1:0]        kind;
    logic                              bank;
    logic [pfe_pkg::ENTRY_FIELD_W-1:0] entry;
    pfe_pkg::rgb_t                     color;
    logic [pfe_pkg::MODE_W-1:0]        mode;
  } fade_cmd_t;

  typedef struct packed {
    pfe_pkg::rgb_t color;
    logic          done;
  } fade_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Item port; every field is driven from one struct so they move together.
  logic      start   = 1'b0;
  logic      busy;
  fade_cmd_t drv_cmd = '0;

  logic       result_valid_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       done_res_o;

  logic                           cfg_we_i   = 1'b0;
  logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [pfe_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  palette_fade_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (drv_cmd.kind),
    .bank_i        (drv_cmd.bank),
    .entry_i       (drv_cmd.entry),
    .red_in_i      (drv_cmd.color.r),
    .green_in_i    (drv_cmd.color.g),
    .blue_in_i     (drv_cmd.color.b),
    .fade_mode_i   (drv_cmd.mode),
    .result_valid_o(result_valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .done_res_o    (done_res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Palette predictor: own copy of both palettes, the fade control and the
  // three registers. Updated once per accepted item, in acceptance order.
  // ---------------------------------------------------------------------------
  pfe_pkg::rgb_t              cur_pal [TOTAL_ENTRIES];
  pfe_pkg::rgb_t              tgt_pal [TOTAL_ENTRIES];
  logic [pfe_pkg::STEP_W-1:0] step_cnt;
  logic [pfe_pkg::MODE_W-1:0] run_mode;
  logic [5:0]                 cfg_first;
  logic [5:0]                 cfg_last_off;
  logic                       cfg_skip;

  // Top of the fade-in range, clipped at the last entry of a bank.
  function automatic int fade_in_top();
    int top;
    top = int'(cfg_first) + int'(cfg_last_off);
    if (top > pfe_pkg::BANK_ENTRIES - 1) top = pfe_pkg::BANK_ENTRIES - 1;
    return top;
  endfunction

  // Move one channel 32 toward the target; falling steps add 224 so the
  // 8-bit wrap matches a subtraction of 32.
  function automatic pfe_pkg::rgb_t step_to_target(pfe_pkg::rgb_t c, pfe_pkg::rgb_t t,
                                                   logic rising);
    pfe_pkg::rgb_t n;
    logic [7:0]    d;
    n = c;
    d = rising ? pfe_pkg::STEP_DELTA : 8'(8'd0 - pfe_pkg::STEP_DELTA);
    if (t == c) return n;
    if (rising ? (t.b > c.b) : (t.b < c.b)) n.b = c.b + d;
    else if (rising ? (t.g > c.g) : (t.g < c.g)) n.g = c.g + d;
    else if (rising ? (t.r > c.r) : (t.r < c.r)) n.r = c.r + d;
    return n;
  endfunction

  function automatic pfe_pkg::rgb_t step_darker(pfe_pkg::rgb_t c);
    pfe_pkg::rgb_t n;
    n = c;
    if (c.r != 8'd0) n.r = c.r - pfe_pkg::STEP_DELTA;
    else if (c.g != 8'd0) n.g = c.g - pfe_pkg::STEP_DELTA;
    else if (c.b != 8'd0) n.b = c.b - pfe_pkg::STEP_DELTA;
    return n;
  endfunction

  function automatic pfe_pkg::rgb_t step_brighter(pfe_pkg::rgb_t c);
    pfe_pkg::rgb_t n;
    n = c;
    if (c.r != pfe_pkg::WHITE_LEVEL) n.r = c.r + pfe_pkg::STEP_DELTA;
    else if (c.g != pfe_pkg::WHITE_LEVEL) n.g = c.g + pfe_pkg::STEP_DELTA;
    else if (c.b != pfe_pkg::WHITE_LEVEL) n.b = c.b + pfe_pkg::STEP_DELTA;
    return n;
  endfunction

  // One frame of the running fade; returns the done flag of the tick.
  function automatic logic frame_tick_predict();
    int lo;
    int hi;
    int banks;
    int k;
    if (run_mode < pfe_pkg::MODE_FADE_IN || run_mode > pfe_pkg::MODE_FLASH_OUT) return 1'b1;
    if (run_mode == pfe_pkg::MODE_FADE_IN || run_mode == pfe_pkg::MODE_FLASH_IN) begin
      if (run_mode == pfe_pkg::MODE_FADE_IN) begin
        lo = int'(cfg_first);
        hi = fade_in_top();
      end else begin
        lo = 0;
        hi = pfe_pkg::BANK_ENTRIES - 1;
      end
      banks = cfg_skip ? 1 : 2;
      for (int bk = 0; bk < banks; bk++) begin
        for (int i = lo; i <= hi; i++) begin
          k = bk * pfe_pkg::BANK_ENTRIES + i;
          cur_pal[k] = step_to_target(cur_pal[k], tgt_pal[k],
                                      run_mode == pfe_pkg::MODE_FADE_IN);
        end
      end
    end else begin
      for (int i = 0; i < TOTAL_ENTRIES; i++) begin
        cur_pal[i] = (run_mode == pfe_pkg::MODE_FADE_OUT) ? step_darker(cur_pal[i])
                                                          : step_brighter(cur_pal[i]);
      end
    end
    step_cnt = step_cnt + 1'b1;
    if (step_cnt >= pfe_pkg::STEPS_LAST) begin
      step_cnt = '0;
      run_mode = pfe_pkg::MODE_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fade_reply_t palette_apply_item(fade_cmd_t c);
    fade_reply_t rep;
    int          k;
    int          top;
    rep = '0;
    k   = int'(c.bank) * pfe_pkg::BANK_ENTRIES + int'(c.entry);
    case (c.kind)
      pfe_pkg::KIND_WR_TARGET:  tgt_pal[k] = c.color;
      pfe_pkg::KIND_WR_CURRENT: cur_pal[k] = c.color;
      pfe_pkg::KIND_START: begin
        step_cnt = '0;
        if (c.mode >= pfe_pkg::MODE_FADE_IN && c.mode <= pfe_pkg::MODE_FLASH_OUT) begin
          run_mode = c.mode;
          if (c.mode == pfe_pkg::MODE_FADE_IN) begin
            top = fade_in_top();
            for (int i = int'(cfg_first); i <= top; i++) cur_pal[i] = '0;
          end else if (c.mode == pfe_pkg::MODE_FLASH_IN) begin
            for (int i = 0; i < pfe_pkg::BANK_ENTRIES; i++) begin
              cur_pal[i] = '{r: pfe_pkg::WHITE_LEVEL, g: pfe_pkg::WHITE_LEVEL,
                             b: pfe_pkg::WHITE_LEVEL};
            end
          end
        end else begin
          run_mode = pfe_pkg::MODE_IDLE;
        end
      end
      pfe_pkg::KIND_TICK:       rep.done  = frame_tick_predict();
      pfe_pkg::KIND_RD_CURRENT: rep.color = cur_pal[k];
      default: ;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------
  fade_cmd_t   pending_items[$];
  fade_reply_t expected_replies[$];
  fade_cmd_t   head_item;
  logic        holding    = 1'b0;   // head_item waits to be taken
  logic        item_taken = 1'b0;   // set at the edge that took an item
  int          idle_pct   = 18;
  int          mismatch_count = 0;

  // Present the head item at each falling edge unless this cycle idles. Dropping
  // start while busy is harmless and lets gaps fall anywhere in the block's work.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (item_taken) holding = 1'b0;
      if (!holding && pending_items.size() != 0) begin
        head_item = pending_items.pop_front();
        holding   = 1'b1;
      end
      if (holding && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        drv_cmd <= head_item;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s differs, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Check a reply before predicting a newly taken item: a reply and the next
  // item can share one edge, and the reply always belongs to the older item.
  always @(posedge clk_i) begin
    fade_reply_t want;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with nothing pending, actual rgb %0d %0d %0d done %0d",
                   $time, red_out_o, green_out_o, blue_out_o, done_res_o);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("red", want.color.r, red_out_o);
          compare_field("green", want.color.g, green_out_o);
          compare_field("blue", want.color.b, blue_out_o);
          compare_field("done", {7'd0, want.done}, {7'd0, done_res_o});
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        expected_replies.push_back(palette_apply_item(drv_cmd));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int useful_items = 0;   // items that do something; unused kinds do not count

  // Bias levels toward multiples of 32 and the rails so fades converge.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(7) * 32);
      1:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pfe_pkg::rgb_t rand_color();
    pfe_pkg::rgb_t c;
    c.r = rand_level();
    c.g = rand_level();
    c.b = rand_level();
    return c;
  endfunction

  task automatic queue_item(logic [pfe_pkg::KIND_W-1:0] kind, logic bank,
                            logic [pfe_pkg::ENTRY_FIELD_W-1:0] entry, pfe_pkg::rgb_t color,
                            logic [pfe_pkg::MODE_W-1:0] mode);
    fade_cmd_t c;
    c.kind  = kind;
    c.bank  = bank;
    c.entry = entry;
    c.color = color;
    c.mode  = mode;
    pending_items.push_back(c);
    if (kind <= pfe_pkg::KIND_RD_CURRENT) useful_items++;
  endtask

  // Queue an item of the given kind with every other field random.
  task automatic queue_kind(logic [pfe_pkg::KIND_W-1:0] kind, logic [pfe_pkg::MODE_W-1:0] mode);
    queue_item(kind, 1'($urandom_range(1)), 6'($urandom_range(63)), rand_color(), mode);
  endtask

  // A fade as firmware runs it: a few writes, a start, a frame of ticks with
  // reads in between, then reads of the result.
  task automatic queue_fade_sequence();
    int n;
    n = $urandom_range(6);
    repeat (n) queue_kind($urandom_range(1) ? pfe_pkg::KIND_WR_TARGET
                                            : pfe_pkg::KIND_WR_CURRENT,
                          3'($urandom_range(7)));
    queue_kind(pfe_pkg::KIND_START, 3'($urandom_range(1, 4)));
    n = $urandom_range(18, 25);   // short runs end in a restart, long ones in idle ticks
    repeat (n) begin
      queue_kind(pfe_pkg::KIND_TICK, 3'($urandom_range(7)));
      if ($urandom_range(99) < 25) queue_kind(pfe_pkg::KIND_RD_CURRENT, 3'($urandom_range(7)));
      if ($urandom_range(99) < 5) queue_kind(pfe_pkg::KIND_WR_CURRENT, 3'($urandom_range(7)));
    end
    n = $urandom_range(1, 4);
    repeat (n) queue_kind(pfe_pkg::KIND_RD_CURRENT, 3'($urandom_range(7)));
  endtask

  // Noise: any kind, any mode, including unused kinds and invalid modes.
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) queue_kind(3'($urandom_range(7)), 3'($urandom_range(7)));
  endtask

  // Hold until every queued item has been taken and answered, then let the
  // block settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (holding || start || pending_items.size() != 0 || expected_replies.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [pfe_pkg::CFG_IDX_W-1:0] idx,
                           logic [pfe_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pfe_pkg::CFG_FIRST_ENTRY: cfg_first    = val;
      pfe_pkg::CFG_LAST_OFFSET: cfg_last_off = val;
      pfe_pkg::CFG_SKIP_BANK:   cfg_skip     = val[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int unsigned first_tbl [5] = '{0, 63, 63, 0, 20};
  int unsigned last_tbl  [5] = '{63, 63, 0, 0, 10};
  int unsigned skip_tbl  [5] = '{0, 1, 0, 1, 0};

  initial begin
    int            goal;
    int            base;
    pfe_pkg::rgb_t white;
    pfe_pkg::rgb_t black;
    white = '{r: 8'hFF, g: 8'hFF, b: 8'hFF};
    black = '0;

    // Predictor starts in the reset state of the block.
    foreach (cur_pal[i]) cur_pal[i] = '0;
    foreach (tgt_pal[i]) tgt_pal[i] = '0;
    step_cnt     = '0;
    run_mode     = pfe_pkg::MODE_IDLE;
    cfg_first    = 6'd0;
    cfg_last_off = 6'd63;
    cfg_skip     = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill every target entry first: fade-in and flash-in ticks step entries toward
    // their targets, and an unwritten target must never be read.
    for (int i = 0; i < TOTAL_ENTRIES; i++) begin
      queue_item(pfe_pkg::KIND_WR_TARGET, 1'(i / pfe_pkg::BANK_ENTRIES),
                 6'(i % pfe_pkg::BANK_ENTRIES), rand_color(), pfe_pkg::MODE_IDLE);
    end

    // Directed: reset black, idle tick, rails, invalid modes, unused kinds,
    // restart while running and every mode once.
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b0, 6'd0, white, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_WR_CURRENT, 1'b1, 6'd63, white, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b1, 6'd63, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_WR_CURRENT, 1'b0, 6'd63, '{r: 8'h00, g: 8'hFF, b: 8'h00},
               pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_TICK, 1'b1, 6'd63, white, 3'd7);
    queue_item(pfe_pkg::KIND_START, 1'b1, 6'd63, white, 3'd7);
    queue_item(3'd5, 1'b1, 6'd63, white, 3'd7);
    queue_item(3'd6, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(3'd7, 1'b1, 6'd63, white, 3'd7);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, pfe_pkg::MODE_FADE_OUT);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b1, 6'd63, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, pfe_pkg::MODE_FLASH_OUT);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b1, 6'd63, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, pfe_pkg::MODE_FADE_IN);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, pfe_pkg::MODE_FLASH_IN);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_RD_CURRENT, 1'b1, 6'd0, black, pfe_pkg::MODE_IDLE);
    queue_item(pfe_pkg::KIND_START, 1'b0, 6'd0, black, 3'd5);
    queue_item(pfe_pkg::KIND_TICK, 1'b0, 6'd0, black, pfe_pkg::MODE_IDLE);
    wait_drained();
    base = useful_items;

    // Random phases, each under its own register setting; the extremes come
    // first, then random settings. One phase runs without any idle cycles.
    // Goals are cumulative so the whole run stays near the item budget.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 5) begin
        write_reg(pfe_pkg::CFG_FIRST_ENTRY, 6'(first_tbl[phase]));
        write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'(last_tbl[phase]));
        write_reg(pfe_pkg::CFG_SKIP_BANK, 6'(skip_tbl[phase]));
      end else begin
        write_reg(pfe_pkg::CFG_FIRST_ENTRY, 6'($urandom_range(63)));
        write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'($urandom_range(63)));
        write_reg(pfe_pkg::CFG_SKIP_BANK, 6'($urandom_range(1)));
      end
      idle_pct = (phase == 3) ? 0 : 18;
      goal     = base + ((ITEM_BUDGET - base) * (phase + 1)) / PHASES;
      do begin
        if ($urandom_range(99) < 70) queue_fade_sequence();
        else queue_noise();
      end while (useful_items < goal);
      wait_drained();
    end

    // Catch any stray reply before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
